### rtl/core/urc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urc_pkg : shared types and constants of the ultrasonic ranger controller
// Command and status types between controller and datapath, plus the fixed
// ranging constants and reciprocals.
// ---------------------------------------------------------------------------
package urc_pkg;

    localparam int unsigned PERIOD_RESET = 25000;
    localparam int unsigned PULSE_RESET  = 3;
    localparam int unsigned SOUND_BASE   = 331300;
    localparam int unsigned SOUND_SLOPE  = 606;
    localparam int unsigned SPEED_SHIFT  = 5;        // prescaler 64 / 2
    localparam int unsigned DIV_TEN      = 10;
    localparam int unsigned DIV_KILO     = 1000;
    localparam int unsigned CFG_IDX_W    = 8;

    // working widths; each holds the largest value of its step
    localparam int unsigned ACC_W    = 30;   // scaled speed * echo width
    localparam int unsigned SLOPE_W  = 20;   // 606 * 1023
    localparam int unsigned SPEED_W  = 24;   // (331300 + 61993) * 32
    localparam int unsigned SCALED_W = 14;   // 12585376 / 1000

    // exact reciprocals: m = ceil(2^(n + clog2(d)) / d) for n-bit dividends
    localparam int unsigned TEN_SHIFT = SLOPE_W + $clog2(DIV_TEN);
    localparam longint unsigned TEN_RECIP =
        ((64'd1 << TEN_SHIFT) + 64'(DIV_TEN) - 64'd1) / 64'(DIV_TEN);
    localparam int unsigned TEN_RECIP_W = $clog2(TEN_RECIP + 64'd1);

    localparam int unsigned KILO_SHIFT = SPEED_W + $clog2(DIV_KILO);
    localparam longint unsigned KILO_RECIP =
        ((64'd1 << KILO_SHIFT) + 64'(DIV_KILO) - 64'd1) / 64'(DIV_KILO);
    localparam int unsigned KILO_RECIP_W = $clog2(KILO_RECIP + 64'd1);

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PULSE  = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,    // one timer tick, load result
        OP_EMPTY,   // read with no data, load zero result
        OP_START,   // load 606*T, latch temperature
        OP_STEP,    // one distance step, picked by the step code
        OP_FINISH   // load distance result, clear ready flag
    } t_op;

    typedef enum logic [1:0] {
        STEP_TEN,   // speed = base + 606*T / 10, times 32
        STEP_KILO,  // speed*32 / 1000
        STEP_DUR,   // scaled * echo width
        STEP_CLK    // / CLOCK_KHZ
    } t_step;

    typedef struct packed {
        t_op   op;
        t_step step;
    } t_dp_cmd;

    typedef struct packed {
        logic ready_flag;
    } t_dp_status;

endpackage

### rtl/core/urc_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urc_dpath : ranger datapath
// Repeat timer, trigger and echo capture, config registers, the distance
// steps by reciprocal multiplication and the result registers.
// ---------------------------------------------------------------------------
module urc_dpath #(
    parameter int unsigned CLOCK_KHZ = 16000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  urc_pkg::t_dp_cmd                  i_cmd_dp,
    output urc_pkg::t_dp_status               o_status,
    input  logic                              i_echo_level,
    input  logic [9:0]                        i_temperature_tenths,
    input  logic                              i_cfg_we,
    input  logic [urc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                       i_cfg_data,
    output logic                              o_trigger_level,
    output logic                              o_data_ready,
    output logic [15:0]                       o_distance_mm,
    output logic [9:0]                        o_temperature_out
);

    localparam int unsigned AW  = urc_pkg::ACC_W;
    localparam int unsigned SW  = urc_pkg::SPEED_W;
    localparam int unsigned TPW = urc_pkg::SLOPE_W + urc_pkg::TEN_RECIP_W;
    localparam int unsigned KPW = urc_pkg::SPEED_W + urc_pkg::KILO_RECIP_W;

    // reciprocal of the clock rate, exact for any AW-bit dividend
    localparam int unsigned CLK_SHIFT = AW + $clog2(CLOCK_KHZ);
    localparam longint unsigned CLK_RECIP =
        ((64'd1 << CLK_SHIFT) + 64'(CLOCK_KHZ) - 64'd1) / 64'(CLOCK_KHZ);
    localparam int unsigned CLK_RECIP_W = $clog2(CLK_RECIP + 64'd1);
    localparam int unsigned CPW = AW + CLK_RECIP_W;

    logic [15:0] r_period, r_pulse;
    logic [15:0] r_tick, n_tick;
    logic [15:0] r_start, r_dur;
    logic        r_flag, r_await, r_prev, r_trig;
    logic        n_trig;

    logic [AW-1:0]  r_acc, n_acc;
    logic [9:0]     r_temp;

    logic [15:0] r_o_dist;
    logic [9:0]  r_o_temp;
    logic        r_o_trig, r_o_rdy;

    logic        rise, fall;
    logic [urc_pkg::SLOPE_W-1:0] slope_prod;
    logic [TPW-1:0] ten_prod;
    logic [SW-1:0]  speed_sum;
    logic [SW-1:0]  speed_sh;
    logic [KPW-1:0] kilo_prod;
    logic [AW-1:0]  dur_prod;
    logic [CPW-1:0] clk_prod;

    // tick update
    always_comb begin
        n_tick = (r_tick == r_period) ? 16'd0 : r_tick + 16'd1;
        n_trig = r_trig;
        if (n_tick == r_period) n_trig = 1'b1;
        if (n_tick == r_pulse)  n_trig = 1'b0;
        rise = i_echo_level & ~r_prev;
        fall = ~i_echo_level & r_prev;
    end

    // one multiply per step; each quotient is a product shifted down
    always_comb begin
        slope_prod = urc_pkg::SLOPE_W'(urc_pkg::SOUND_SLOPE)
                   * urc_pkg::SLOPE_W'(i_temperature_tenths);
        ten_prod   = TPW'(r_acc[urc_pkg::SLOPE_W-1:0]) * TPW'(urc_pkg::TEN_RECIP);
        speed_sum  = SW'(urc_pkg::SOUND_BASE) + SW'(ten_prod >> urc_pkg::TEN_SHIFT);
        speed_sh   = speed_sum << urc_pkg::SPEED_SHIFT;
        kilo_prod  = KPW'(r_acc[SW-1:0]) * KPW'(urc_pkg::KILO_RECIP);
        dur_prod   = AW'(r_acc[urc_pkg::SCALED_W-1:0]) * AW'(r_dur);
        clk_prod   = CPW'(r_acc) * CPW'(CLK_RECIP);
        n_acc = r_acc;
        if (i_cmd_dp.op == urc_pkg::OP_START) begin
            n_acc = AW'(slope_prod);
        end else if (i_cmd_dp.op == urc_pkg::OP_STEP) begin
            unique case (i_cmd_dp.step)
                urc_pkg::STEP_TEN:  n_acc = AW'(speed_sh);
                urc_pkg::STEP_KILO: n_acc = AW'(kilo_prod >> urc_pkg::KILO_SHIFT);
                urc_pkg::STEP_DUR:  n_acc = dur_prod;
                urc_pkg::STEP_CLK:  n_acc = AW'(clk_prod >> CLK_SHIFT);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'(urc_pkg::PERIOD_RESET);
            r_pulse  <= 16'(urc_pkg::PULSE_RESET);
            r_tick   <= '0;
            r_start  <= '0;
            r_dur    <= '0;
            r_flag   <= 1'b0;
            r_await  <= 1'b0;
            r_prev   <= 1'b0;
            r_trig   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == urc_pkg::REG_PERIOD) r_period <= i_cfg_data;
                if (i_cfg_index == urc_pkg::REG_PULSE)  r_pulse  <= i_cfg_data;
            end
            if (i_cmd_dp.op == urc_pkg::OP_TICK) begin
                r_tick <= n_tick;
                r_trig <= n_trig;
                r_prev <= i_echo_level;
                if (!r_await) begin
                    if (rise) begin
                        r_start <= n_tick;
                        r_await <= 1'b1;
                    end
                end else if (fall) begin
                    r_dur   <= n_tick - r_start;
                    r_flag  <= 1'b1;
                    r_await <= 1'b0;
                end
            end
            if (i_cmd_dp.op == urc_pkg::OP_FINISH) r_flag <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_cmd_dp.op == urc_pkg::OP_START)
            r_temp <= i_temperature_tenths;
        unique case (i_cmd_dp.op)
            urc_pkg::OP_TICK: begin
                r_o_trig <= n_trig;
                r_o_rdy  <= r_flag | (r_await & fall);
                r_o_dist <= '0;
                r_o_temp <= '0;
            end
            urc_pkg::OP_EMPTY: begin
                r_o_trig <= r_trig;
                r_o_rdy  <= 1'b0;
                r_o_dist <= '0;
                r_o_temp <= '0;
            end
            urc_pkg::OP_FINISH: begin
                r_o_trig <= r_trig;
                r_o_rdy  <= 1'b1;
                r_o_dist <= (r_acc[AW-1:16] != '0) ? 16'hFFFF : r_acc[15:0];
                r_o_temp <= r_temp;
            end
            default: begin
                r_o_trig <= r_o_trig;
            end
        endcase
    end

    assign o_status.ready_flag = r_flag;

    assign o_trigger_level   = r_o_trig;
    assign o_data_ready      = r_o_rdy;
    assign o_distance_mm     = r_o_dist;
    assign o_temperature_out = r_o_temp;

endmodule

### rtl/core/urc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urc_ctrl : ranger controller
// Handshakes and the sequence of the distance steps on a read.
// ---------------------------------------------------------------------------
module urc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  urc_pkg::t_dp_status  i_status,
    output urc_pkg::t_dp_cmd     o_cmd_dp
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_TEN    = 6'b000010,
        ST_KILO   = 6'b000100,
        ST_DUR    = 6'b001000,
        ST_CLK    = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   load_out;

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd_dp.op   = urc_pkg::OP_NONE;
        o_cmd_dp.step = urc_pkg::STEP_TEN;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!i_cmd) begin
                        o_cmd_dp.op = urc_pkg::OP_TICK;
                    end else if (i_status.ready_flag) begin
                        o_cmd_dp.op = urc_pkg::OP_START;
                        n_state     = ST_TEN;
                    end else begin
                        o_cmd_dp.op = urc_pkg::OP_EMPTY;
                    end
                end
            end
            ST_TEN: begin
                o_cmd_dp.op   = urc_pkg::OP_STEP;
                o_cmd_dp.step = urc_pkg::STEP_TEN;
                n_state       = ST_KILO;
            end
            ST_KILO: begin
                o_cmd_dp.op   = urc_pkg::OP_STEP;
                o_cmd_dp.step = urc_pkg::STEP_KILO;
                n_state       = ST_DUR;
            end
            ST_DUR: begin
                o_cmd_dp.op   = urc_pkg::OP_STEP;
                o_cmd_dp.step = urc_pkg::STEP_DUR;
                n_state       = ST_CLK;
            end
            ST_CLK: begin
                o_cmd_dp.op   = urc_pkg::OP_STEP;
                o_cmd_dp.step = urc_pkg::STEP_CLK;
                n_state       = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd_dp.op = urc_pkg::OP_FINISH;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign load_out = (o_cmd_dp.op == urc_pkg::OP_TICK)
                   || (o_cmd_dp.op == urc_pkg::OP_EMPTY)
                   || (o_cmd_dp.op == urc_pkg::OP_FINISH);

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if (load_out)    n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/ultrasonic_ranger_controller_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ultrasonic_ranger_controller_unit : ultrasonic time-of-flight ranger
// Repeat timer with trigger pulse, echo edge capture and a temperature
// compensated distance read in millimetres.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------
//  in       | sink      | i_in_valid / o_in_ready | cmd, echo_level, temp
//  out      | source    | o_out_valid/i_out_ready | trigger, ready, dist, temp
//  cfg      | sink      | i_cfg_valid/o_cfg_ready | index, data (16 bit)
//
//  A tick beat or a read beat with no data is taken from idle; the result is
//  registered and shown the cycle after acceptance.
//  A read beat with data runs in order: load 606*T, four single-multiply
//  steps (/10 by reciprocal plus base speed, /1000 by reciprocal, times the
//  echo width, /CLOCK_KHZ by reciprocal), then the result load.
//  A new beat is taken while a result waits, provided that result is taken
//  in the same cycle; a held output stalls the input.
//  Reset is synchronous, active low; config writes are always accepted.
//
module ultrasonic_ranger_controller_unit #(
    parameter int unsigned CLOCK_KHZ = 16000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic                              i_echo_level,
    input  logic [9:0]                        i_temperature_tenths,
    // result beats
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_trigger_level,
    output logic                              o_data_ready,
    output logic [15:0]                       o_distance_mm,
    output logic [9:0]                        o_temperature_out,
    // config writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [urc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);

    urc_pkg::t_dp_cmd    dp_cmd;
    urc_pkg::t_dp_status dp_status;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    urc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd_dp    (dp_cmd)
    );

    // datapath: timer, capture, distance arithmetic, result registers
    urc_dpath #(
        .CLOCK_KHZ (CLOCK_KHZ)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd_dp             (dp_cmd),
        .o_status             (dp_status),
        .i_echo_level         (i_echo_level),
        .i_temperature_tenths (i_temperature_tenths),
        .i_cfg_we             (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_trigger_level      (o_trigger_level),
        .o_data_ready         (o_data_ready),
        .o_distance_mm        (o_distance_mm),
        .o_temperature_out    (o_temperature_out)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench : ultrasonic ranger controller, self-checking
// Drives tick and read beats through the valid/ready input channel, writes
// the period and pulse registers between phases, and checks every result
// beat field by field against a cycle-free predictor of the ranger.
// ---------------------------------------------------------------------------
module testbench;

    // command codes carried on i_cmd
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // an index that maps to no register; all bits set
    localparam logic [urc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = '1;

    localparam int unsigned CLOCK_KHZ       = 16000;
    localparam int unsigned IDLE_PCT        = 11;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES   = 120;   // longer than one read
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned RANDOM_ITEMS    = 1800;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned MAX_REPORTS     = 10;

    // -----------------------------------------------------------------------
    // DUT ports; every input holds a known value from time zero
    // -----------------------------------------------------------------------
    logic                          i_clk                = 1'b0;
    logic                          i_rst_n              = 1'b0;
    logic                          i_in_valid           = 1'b0;
    logic                          o_in_ready;
    logic                          i_cmd                = CMD_TICK;
    logic                          i_echo_level         = 1'b0;
    logic [9:0]                    i_temperature_tenths = '0;
    logic                          o_out_valid;
    logic                          i_out_ready          = 1'b0;
    logic                          o_trigger_level;
    logic                          o_data_ready;
    logic [15:0]                   o_distance_mm;
    logic [9:0]                    o_temperature_out;
    logic                          i_cfg_valid          = 1'b0;
    logic                          o_cfg_ready;
    logic [urc_pkg::CFG_IDX_W-1:0] i_cfg_index          = '0;
    logic [15:0]                   i_cfg_data           = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ultrasonic_ranger_controller_unit #(
        .CLOCK_KHZ (CLOCK_KHZ)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_cmd                (i_cmd),
        .i_echo_level         (i_echo_level),
        .i_temperature_tenths (i_temperature_tenths),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_trigger_level      (o_trigger_level),
        .o_data_ready         (o_data_ready),
        .o_distance_mm        (o_distance_mm),
        .o_temperature_out    (o_temperature_out),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // -----------------------------------------------------------------------
    // Predictor: a private copy of the ranger state and its two registers.
    // It is stepped once per accepted input beat, from the monitor below.
    // -----------------------------------------------------------------------
    typedef struct packed {
        logic        trig;
        logic        ready;
        logic [15:0] dist_mm;
        logic [9:0]  temp;
    } t_ranger_beat;

    t_ranger_beat beats_due[$];      // predicted result beats, oldest first

    logic [15:0] period_q    = 16'(urc_pkg::PERIOD_RESET);
    logic [15:0] pulse_q     = 16'(urc_pkg::PULSE_RESET);
    logic [15:0] timer_q     = '0;
    logic [15:0] rise_stamp  = '0;
    logic [15:0] echo_width  = '0;
    logic        meas_ready  = 1'b0;
    logic        in_echo     = 1'b0;  // rising edge seen, waiting for the fall
    logic        echo_prev   = 1'b0;
    logic        trig_q      = 1'b0;

    // Speed of sound for the temperature, scaled to mm per prescaled tick,
    // then multiplied by the echo width and divided by CLOCK_KHZ, saturated to 16 bits; every division truncates.
    function automatic logic [15:0] distance_for(input logic [9:0] temp,
                                                 input logic [15:0] width);
        longint unsigned speed;
        longint unsigned scaled;
        longint unsigned range_mm;
        speed    = 64'(urc_pkg::SOUND_BASE)
                 + (64'(urc_pkg::SOUND_SLOPE) * 64'(temp)) / 64'(urc_pkg::DIV_TEN);
        scaled   = (speed << urc_pkg::SPEED_SHIFT) / 64'(urc_pkg::DIV_KILO);
        range_mm = (scaled * 64'(width)) / 64'(CLOCK_KHZ);
        if (range_mm > 64'hFFFF)
            range_mm = 64'hFFFF;
        return range_mm[15:0];
    endfunction

    function automatic t_ranger_beat step_ranger(input logic cmd, input logic echo,
                                                 input logic [9:0] temp);
        t_ranger_beat beat;
        beat = '0;
        if (cmd == CMD_TICK) begin
            // counter first, then trigger set, then trigger clear, then edges
            timer_q = (timer_q == period_q) ? 16'd0 : timer_q + 16'd1;
            if (timer_q == period_q)
                trig_q = 1'b1;
            if (timer_q == pulse_q)
                trig_q = 1'b0;
            if (!in_echo) begin
                if (echo && !echo_prev) begin
                    rise_stamp = timer_q;
                    in_echo    = 1'b1;
                end
            end else if (!echo && echo_prev) begin
                echo_width = timer_q - rise_stamp;  // modulo 2^16
                meas_ready = 1'b1;
                in_echo    = 1'b0;
            end
            echo_prev  = echo;
            beat.ready = meas_ready;
        end else begin
            beat.ready = meas_ready;
            if (meas_ready) begin
                beat.temp    = temp;
                beat.dist_mm = distance_for(temp, echo_width);
                meas_ready   = 1'b0;
            end
        end
        beat.trig = trig_q;
        return beat;
    endfunction

    // -----------------------------------------------------------------------
    // Monitor and watchdog. All handshakes are sampled at the rising edge,
    // before any register in the block or the bench updates.
    // -----------------------------------------------------------------------
    int unsigned mismatches  = 0;
    int unsigned quiet_count = 0;

    task automatic flag_error(input string why, input t_ranger_beat want,
                              input t_ranger_beat seen);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: exp trig %0b rdy %0b dist %0d temp %0d",
                     $realtime, why, want.trig, want.ready, want.dist_mm, want.temp,
                     ", got trig %0b rdy %0b dist %0d temp %0d",
                     seen.trig, seen.ready, seen.dist_mm, seen.temp);
    endtask

    always @(posedge i_clk) begin
        t_ranger_beat seen;
        t_ranger_beat want;
        if (i_rst_n) begin
            seen = {o_trigger_level, o_data_ready, o_distance_mm, o_temperature_out};
            // check before predicting: a beat accepted now cannot have its
            // result on the output in the same cycle
            if (o_out_valid && i_out_ready) begin
                if (beats_due.size() == 0) begin
                    flag_error("result beat with nothing expected", '0, seen);
                end else begin
                    want = beats_due.pop_front();
                    if (seen !== want)
                        flag_error("result beat differs", want, seen);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    urc_pkg::REG_PERIOD: period_q = i_cfg_data;
                    urc_pkg::REG_PULSE:  pulse_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                beats_due.push_back(step_ranger(i_cmd, i_echo_level, i_temperature_tenths));

            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random stalls, none while steady is set, and a long
    // hold-off on request, counted down here.
    // -----------------------------------------------------------------------
    logic        steady    = 1'b0;
    int unsigned hold_ask  = 0;
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_ask != 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // -----------------------------------------------------------------------
    // Sender side
    // -----------------------------------------------------------------------

    // One input beat. Valid stays high straight into the next beat unless a
    // random gap is taken first; returns at the accepting edge.
    task automatic send_item(input logic cmd, input logic echo, input logic [9:0] temp);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_cmd                <= cmd;
        i_echo_level         <= echo;
        i_temperature_tenths <= temp;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop sending, let every predicted beat come back, then allow for any
    // work still in flight before touching the registers.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (beats_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; valid drops again before the task returns, so valid never toggles
    // twice in one step across back-to-back writes
    task automatic write_reg(input logic [urc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [15:0] period, input logic [15:0] pulse);
        wait_idle();
        write_reg(urc_pkg::REG_PERIOD, period);
        write_reg(urc_pkg::REG_PULSE, pulse);
    endtask

    // Mostly whole measurements: quiet ticks, an echo pulse, a falling edge
    // and a read, all with random content. The rest is loose noise.
    task automatic random_items(input int unsigned count);
        int unsigned sent;
        int unsigned quiet;
        int unsigned high;
        int unsigned trail;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 80) begin
                quiet = $urandom_range(0, 4);
                high  = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300)
                                                     : $urandom_range(1, 12);
                trail = $urandom_range(0, 2);
                repeat (quiet) send_item(CMD_TICK, 1'b0, 10'($urandom));
                repeat (high) send_item(CMD_TICK, 1'b1, 10'($urandom));
                repeat (trail + 1) send_item(CMD_TICK, 1'b0, 10'($urandom));
                send_item(CMD_READ, 1'($urandom), 10'($urandom));
                sent += quiet + high + trail + 2;
            end else begin
                repeat (6)
                    send_item(($urandom_range(0, 99) < 20) ? CMD_READ : CMD_TICK,
                              1'($urandom), 10'($urandom));
                sent += 6;
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset defaults, reads with and without a measurement, the trigger
    // compares, equal period and pulse, zero period, a counter left above
    // a lowered period, and a write to an unmapped index.
    task automatic test_directed();
        send_item(CMD_READ, 1'b1, 10'd1023);     // read with no data, state untouched
        send_item(CMD_TICK, 1'b0, 10'd0);
        send_item(CMD_TICK, 1'b1, 10'd0);        // rise
        send_item(CMD_TICK, 1'b1, 10'd0);
        send_item(CMD_TICK, 1'b0, 10'd0);        // fall, width 2
        send_item(CMD_READ, 1'b0, 10'd0);        // coldest
        send_item(CMD_READ, 1'b0, 10'd0);        // flag already cleared
        send_item(CMD_TICK, 1'b1, 10'd0);
        send_item(CMD_TICK, 1'b0, 10'd0);
        send_item(CMD_READ, 1'b0, 10'd1023);     // temperature beyond 100.0 C

        set_timing(16'd4, 16'd2);                // trigger high on 4, low on 2
        repeat (7) send_item(CMD_TICK, 1'b0, 10'd0);

        set_timing(16'd3, 16'd3);                // both compares hit; trigger ends low
        repeat (5) send_item(CMD_TICK, 1'b0, 10'd0);

        set_timing(16'd0, 16'd5);                // zero period: counter stays at zero once it wraps there
        repeat (3) send_item(CMD_TICK, 1'b0, 10'd0);

        set_timing(16'd20, 16'd65535);
        repeat (10) send_item(CMD_TICK, 1'b0, 10'd0);
        wait_idle();
        write_reg(urc_pkg::REG_PERIOD, 16'd3);   // counter now above the period
        write_reg(REG_UNMAPPED, 16'hFFFF);       // must change nothing
        repeat (4) send_item(CMD_TICK, 1'b0, 10'd0);
    endtask

    // Receiver holds off while the sender keeps offering beats, so the
    // result register fills and the input stalls.
    task automatic test_hold_off();
        set_timing(16'd6, 16'd2);
        hold_ask = HOLD_OFF_CYCLES;
        random_items(40);
    endtask

    // Random phases across register settings, extremes included; one
    // phase runs with no idling on either side.
    task automatic test_random();
        logic [15:0] period;
        logic [15:0] pulse;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin period = 16'd1;               pulse = 16'd1;     end
                1: begin period = 16'd7;               pulse = 16'd3;     end
                2: begin period = 16'd65535;           pulse = 16'd65535; end
                3: begin period = 16'd0;               pulse = 16'd0;     end
                4: begin period = 16'(urc_pkg::PERIOD_RESET);
                         pulse  = 16'(urc_pkg::PULSE_RESET);              end
                5: begin period = 16'($urandom_range(2, 40));
                         pulse  = 16'($urandom_range(0, 40));             end
                6: begin period = 16'($urandom);       pulse = 16'($urandom); end
                default: begin period = 16'd5;         pulse = 16'd1;     end
            endcase
            set_timing(period, pulse);
            if (p == 6)
                write_reg(urc_pkg::CFG_IDX_W'($urandom_range(2, 254)), 16'($urandom));
            steady = (p == 1);
            random_items(RANDOM_ITEMS / PHASES);
            steady = 1'b0;
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_hold_off();
        test_random();
        wait_idle();

        if (mismatches == 0 && beats_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
rtl/core/urc_pkg.sv
rtl/core/urc_dpath.sv
rtl/core/urc_ctrl.sv
rtl/core/ultrasonic_ranger_controller_unit.sv
tb/testbench.sv
